>>> hw/rtl/e2h_pkg.sv
// e2h_pkg: shared types and constants for the Euler-angle to heading vector block.
// Depends on nothing; imported by the interfaces and by every module.
`default_nettype none

package e2h_pkg;

    localparam int FIELD_W = 16;     // width of every angle and vector field
    localparam int CW      = 34;     // CORDIC datapath width (Q2.30 plus guard bits)
    localparam int STEPS   = 30;     // CORDIC iterations, one cell each
    localparam int POST    = 4;      // stages after the cell row
    localparam int LANES   = 3;      // yaw, pitch, roll

    localparam logic [31:0] CORDIC_X0 = 32'h26DD3B6A;   // 1/gain in Q2.30

    typedef logic [31:0] t_atan_tab [STEPS];
    localparam t_atan_tab ATAN_TAB = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    // state handed from one CORDIC cell to the next
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;   // angle was folded by pi
    } t_cell;

endpackage

`default_nettype wire

>>> hw/rtl/e2h_angle_if.sv
// e2h_angle_if: valid/ready channel carrying one yaw, pitch, roll item.
// Depends on e2h_pkg.
`default_nettype none

interface e2h_angle_if
    import e2h_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] yaw_angle;
    logic signed [FIELD_W-1:0] pitch_angle;
    logic signed [FIELD_W-1:0] roll_angle;

    modport source (output valid, output yaw_angle, output pitch_angle,
                    output roll_angle, input ready);
    modport sink   (input valid, input yaw_angle, input pitch_angle,
                    input roll_angle, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/e2h_vec_if.sv
// e2h_vec_if: valid/ready channel carrying one direction vector item.
// Depends on e2h_pkg.
`default_nettype none

interface e2h_vec_if
    import e2h_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] dir_x;
    logic signed [FIELD_W-1:0] dir_y;
    logic signed [FIELD_W-1:0] dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z,
                    input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/e2h_fold.sv
// e2h_fold: maps an input angle to a 32-bit turn, folds it into +-pi/2 and
// seeds the first CORDIC cell. Depends on e2h_pkg.
`default_nettype none

module e2h_fold
    import e2h_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [FIELD_W-1:0] i_angle,
    output t_cell                   o_cell
);
    localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    logic [31:0] w_turn;
    logic [31:0] w_folded;
    logic        w_flip;
    t_cell       r_cell;
    t_cell       n_cell;

    always_comb begin
        w_turn   = ({{(32 - FIELD_W){1'b0}}, i_angle} & AMASK) << (32 - ANGLE_BITS);
        // quadrants 01 and 10 lie beyond +-pi/2
        w_flip   = w_turn[31] ^ w_turn[30];
        w_folded = {w_turn[31] ^ w_flip, w_turn[30:0]};
        n_cell.x    = CW'(signed'(CORDIC_X0));
        n_cell.y    = '0;
        n_cell.z    = CW'(signed'(w_folded));
        n_cell.flip = w_flip;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule

`default_nettype wire

>>> hw/rtl/e2h_cordic_cell.sv
// e2h_cordic_cell: one rotation-mode CORDIC iteration, registered.
// Depends on e2h_pkg (cell struct, arctangent table).
`default_nettype none

module e2h_cordic_cell
    import e2h_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  t_cell     i_cell,
    output t_cell     o_cell
);
    localparam logic signed [CW-1:0] ATAN = CW'(ATAN_TAB[STEP]);

    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    t_cell                r_cell;
    t_cell                n_cell;

    always_comb begin
        w_dx = i_cell.y >>> STEP;   // floor shift
        w_dy = i_cell.x >>> STEP;
        n_cell.flip = i_cell.flip;
        if (!i_cell.z[CW-1]) begin
            n_cell.x = i_cell.x - w_dx;
            n_cell.y = i_cell.y + w_dy;
            n_cell.z = i_cell.z - ATAN;
        end else begin
            n_cell.x = i_cell.x + w_dx;
            n_cell.y = i_cell.y - w_dy;
            n_cell.z = i_cell.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule

`default_nettype wire

>>> hw/rtl/e2h_vec_calc.sv
// e2h_vec_calc: rounds the CORDIC outputs to sine/cosine, forms the rotated
// unit vector over four registered stages. Depends on e2h_pkg.
`default_nettype none

module e2h_vec_calc
    import e2h_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  t_cell                          i_yaw,
    input  t_cell                          i_pitch,
    input  t_cell                          i_roll,
    output logic signed [FIELD_W-1:0]      o_dir_x,
    output logic signed [FIELD_W-1:0]      o_dir_y,
    output logic signed [FIELD_W-1:0]      o_dir_z
);
    localparam int SW = FRAC_BITS + 2;                 // holds +-1.0
    localparam logic signed [CW-1:0] RHALF = CW'(64'd1 << (29 - FRAC_BITS));
    localparam logic signed [CW-1:0] ONE_C = CW'(64'd1 << FRAC_BITS);
    localparam logic signed [SW:0]   ONE_S = (SW + 1)'(64'd1 << FRAC_BITS);
    localparam logic signed [2*SW-1:0] MHALF = (2 * SW)'(64'd1 << (FRAC_BITS - 1));

    // Q2.30 -> Q(FRAC_BITS), round half up, clamp to +-1
    function automatic logic signed [SW-1:0] sc_round(input logic signed [CW-1:0] v,
                                                      input logic flip);
        logic signed [CW-1:0] f;
        logic signed [CW-1:0] r;
        f = flip ? -v : v;
        r = (f + RHALF) >>> (30 - FRAC_BITS);
        if (r > ONE_C) begin
            r = ONE_C;
        end else if (r < -ONE_C) begin
            r = -ONE_C;
        end
        return SW'(r);
    endfunction

    function automatic logic signed [SW-1:0] mulq(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b);
        logic signed [2*SW-1:0] p;
        p = ((2 * SW)'(a) * (2 * SW)'(b)) + MHALF;
        p = p >>> FRAC_BITS;
        return SW'(p);
    endfunction

    function automatic logic signed [FIELD_W-1:0] clamp_out(input logic signed [SW:0] v);
        logic signed [SW:0] c;
        logic signed [31:0] w;
        c = v;
        if (v > ONE_S) begin
            c = ONE_S;
        end else if (v < -ONE_S) begin
            c = -ONE_S;
        end
        w = 32'(c);
        return w[FIELD_W-1:0];
    endfunction

    // stage 1: sine and cosine
    logic signed [SW-1:0] r_cy, r_sy, r_cp, r_sp, r_cr, r_sr;
    // stage 2: pair products
    logic signed [SW-1:0] r_cysp, r_sysp, r_sysr, r_cysr, r_cpcr, r_cr2;
    // stage 3: triple products
    logic signed [SW-1:0] r_tx, r_ty, r_sysr3, r_cysr3, r_cpcr3;
    // stage 4: output register
    logic signed [FIELD_W-1:0] r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cy <= sc_round(i_yaw.x, i_yaw.flip);
            r_sy <= sc_round(i_yaw.y, i_yaw.flip);
            r_cp <= sc_round(i_pitch.x, i_pitch.flip);
            r_sp <= sc_round(i_pitch.y, i_pitch.flip);
            r_cr <= sc_round(i_roll.x, i_roll.flip);
            r_sr <= sc_round(i_roll.y, i_roll.flip);

            r_cysp <= mulq(r_cy, r_sp);
            r_sysp <= mulq(r_sy, r_sp);
            r_sysr <= mulq(r_sy, r_sr);
            r_cysr <= mulq(r_cy, r_sr);
            r_cpcr <= mulq(r_cp, r_cr);
            r_cr2  <= r_cr;

            r_tx    <= mulq(r_cysp, r_cr2);
            r_ty    <= mulq(r_sysp, r_cr2);
            r_sysr3 <= r_sysr;
            r_cysr3 <= r_cysr;
            r_cpcr3 <= r_cpcr;

            r_x <= clamp_out((SW + 1)'(r_tx) + (SW + 1)'(r_sysr3));
            r_y <= clamp_out((SW + 1)'(r_ty) - (SW + 1)'(r_cysr3));
            r_z <= clamp_out((SW + 1)'(r_cpcr3));
        end
    end

    assign o_dir_x = r_x;
    assign o_dir_y = r_y;
    assign o_dir_z = r_z;
endmodule

`default_nettype wire

>>> hw/rtl/euler_to_heading_vector.sv
// euler_to_heading_vector: top level, yaw/pitch/roll to unit direction vector.
// Depends on e2h_pkg, e2h_angle_if, e2h_vec_if, e2h_fold, e2h_cordic_cell,
// e2h_vec_calc.
//
// Usage:
//   i_ang carries one item per handshake: yaw, pitch and roll as signed binary
//   angles (-2^(ANGLE_BITS-1) is -pi; bits above ANGLE_BITS are ignored).
//   o_vec returns one item per input item, in order: dir_x, dir_y, dir_z as
//   signed Q(FRAC_BITS) values clamped to +-1.0.
// Pipeline: 35 register stages (1 fold stage, 30 CORDIC cells, 4 stages of
//   rounding, products and sums).
// Throughput: one item per cycle unless o_vec is held; the 30-cell CORDIC
//   row per angle is fully pipelined, so a new item may enter every clock.
// Stall: the whole pipe advances as one. When the output item is held
//   (valid high, ready low) every stage freezes and i_ang.ready drops in
//   the same cycle; nothing is lost or repeated.
// Reset: i_rst_n is synchronous, active low, and clears only the valid
//   pipe; data registers are left alone. No state survives between items.
`default_nettype none

module euler_to_heading_vector
    import e2h_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    e2h_angle_if.sink      i_ang,
    e2h_vec_if.source      o_vec
);
    localparam int DEPTH = 1 + STEPS + POST;

    // global advance: output empty or being taken
    logic             w_en;
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;

    // per lane: index 0 yaw, 1 pitch, 2 roll; cell 0 is the fold register
    t_cell            w_cell [LANES][STEPS+1];
    logic [FIELD_W-1:0] w_angle [LANES];

    assign w_en        = !r_vld[DEPTH-1] || o_vec.ready;
    assign i_ang.ready = w_en;

    assign w_angle[0] = i_ang.yaw_angle;
    assign w_angle[1] = i_ang.pitch_angle;
    assign w_angle[2] = i_ang.roll_angle;

    always_comb begin
        n_vld = r_vld;
        if (w_en) begin
            n_vld = {r_vld[DEPTH-2:0], i_ang.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        e2h_fold #(
            .ANGLE_BITS (ANGLE_BITS)
        ) u_fold (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (w_angle[l]),
            .o_cell  (w_cell[l][0])
        );

        // the cell row: each cell runs one iteration and hands on each cycle w_en is high
        for (genvar s = 0; s < STEPS; s++) begin : g_step
            e2h_cordic_cell #(
                .STEP (s)
            ) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_cell (w_cell[l][s]),
                .o_cell (w_cell[l][s+1])
            );
        end
    end

    e2h_vec_calc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_calc (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_yaw   (w_cell[0][STEPS]),
        .i_pitch (w_cell[1][STEPS]),
        .i_roll  (w_cell[2][STEPS]),
        .o_dir_x (o_vec.dir_x),
        .o_dir_y (o_vec.dir_y),
        .o_dir_z (o_vec.dir_z)
    );

    assign o_vec.valid = r_vld[DEPTH-1];

`ifndef SYNTH
    localparam logic signed [FIELD_W-1:0] ONE_O = FIELD_W'(64'd1 << FRAC_BITS);

    // an accepted item enters the valid pipe
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ang.valid && i_ang.ready) |=> r_vld[0])
        else $error("accepted item did not enter the pipe");

    // a held output freezes the front of the pipe
    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vec.valid && !o_vec.ready) |-> !i_ang.ready)
        else $error("input taken while output stalled");

    // a held output item stays valid into the next cycle
    a_hold_keeps_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vec.valid && !o_vec.ready) |=> o_vec.valid)
        else $error("stalled output item dropped");

    // components stay within +-1.0 when they fit the field
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vec.valid |-> ((FRAC_BITS > 14) ||
            ((o_vec.dir_x <= ONE_O) && (o_vec.dir_x >= -ONE_O) &&
             (o_vec.dir_y <= ONE_O) && (o_vec.dir_y >= -ONE_O) &&
             (o_vec.dir_z <= ONE_O) && (o_vec.dir_z >= -ONE_O))))
        else $error("direction component beyond unit range");
`endif
endmodule

`default_nettype wire
